FILE: rtl/lbce_pkg.sv
package lbce_pkg;

    localparam logic [1:0] OP_TICK    = 2'd0;
    localparam logic [1:0] OP_QUERY   = 2'd1;
    localparam logic [1:0] OP_RESTART = 2'd2;
    localparam logic [1:0] OP_NONE    = 2'd3;

    localparam logic [2:0] CFG_RED       = 3'd0;
    localparam logic [2:0] CFG_GREEN     = 3'd1;
    localparam logic [2:0] CFG_BLUE      = 3'd2;
    localparam logic [2:0] CFG_ALPHA     = 3'd3;
    localparam logic [2:0] CFG_SEG_LEN   = 3'd4;
    localparam logic [2:0] CFG_START_POS = 3'd5;
    localparam logic [2:0] CFG_START_REV = 3'd6;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = 2;

    // Division by 240 is a shift by four followed by a division by 15.
    localparam logic [12:0] RECIP_15 = 13'd4369;
    localparam logic [12:0] DIV_15   = 13'd15;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
        logic [6:0] seg_len;
        logic [7:0] start_pos;
        logic       start_rev;
    } t_cfg;

    typedef struct packed {
        logic [1:0] op;
        logic       frac_zero;
        logic [7:0] split;
        logic [7:0] pix;
    } t_cmd;

    typedef struct packed {
        logic empty;
        logic full;
    } t_q_stat;

endpackage

FILE: rtl/led_bouncing_chase_effect.sv
// A pixel query request passes the two-stage split pipeline, the four-entry queue and
// the output register before its result shows. Throughput: one request per cycle, set by
// the split pipeline and the state update, unless the queue fills or the output stalls.
// Reset: i_rst_n is synchronous and active low; it clears the configuration,
// the segment state, the queue and the output valid flag.
module led_bouncing_chase_effect import lbce_pkg::*; #(
    parameter int STRIP_PIXELS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,  // beat_fraction[7:0], pixel_index[15:8]
    input  logic [1:0]  i_s_axis_tuser,  // opcode[1:0]
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [31:0] o_m_axis_tdata,  // out_red, out_green, out_blue, out_alpha
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [7:0]  i_cfg_wdata
);

    t_cfg    r_cfg;
    t_cmd    w_front_cmd;
    t_cmd    w_q_cmd;
    t_q_stat w_q_stat;
    logic    w_push;
    logic    w_pop;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_RED:       r_cfg.red       <= i_cfg_wdata;
                CFG_GREEN:     r_cfg.green     <= i_cfg_wdata;
                CFG_BLUE:      r_cfg.blue      <= i_cfg_wdata;
                CFG_ALPHA:     r_cfg.alpha     <= i_cfg_wdata;
                CFG_SEG_LEN:   r_cfg.seg_len   <= i_cfg_wdata[6:0];
                CFG_START_POS: r_cfg.start_pos <= i_cfg_wdata;
                CFG_START_REV: r_cfg.start_rev <= i_cfg_wdata[0];
                default: begin
                end
            endcase
        end
    end

    lbce_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_valid  (i_s_axis_tvalid),
        .o_ready  (o_s_axis_tready),
        .i_op     (i_s_axis_tuser),
        .i_frac   (i_s_axis_tdata[7:0]),
        .i_pix    (i_s_axis_tdata[15:8]),
        .i_q_stat (w_q_stat),
        .o_push   (w_push),
        .o_cmd    (w_front_cmd)
    );

    lbce_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_cmd   (w_q_cmd),
        .o_stat  (w_q_stat)
    );

    lbce_back #(
        .STRIP_PIXELS (STRIP_PIXELS)
    ) u_back (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (r_cfg),
        .i_cmd    (w_q_cmd),
        .i_q_stat (w_q_stat),
        .o_pop    (w_pop),
        .o_valid  (o_m_axis_tvalid),
        .i_ready  (i_m_axis_tready),
        .o_data   (o_m_axis_tdata)
    );

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_stat.full))
        else $error("queue written while full");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_stat.empty))
        else $error("queue read while empty");

    a_query_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_pop && (w_q_cmd.op == OP_QUERY)) |=> o_m_axis_tvalid)
        else $error("query request produced no result");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid right after reset");

endmodule

FILE: rtl/lbce_front.sv
module lbce_front import lbce_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [1:0]  i_op,
    input  logic [7:0]  i_frac,
    input  logic [7:0]  i_pix,
    input  t_q_stat     i_q_stat,
    output logic        o_push,
    output t_cmd        o_cmd
);

    logic        r_v1, r_v2;
    logic [1:0]  r_op1, r_op2;
    logic        r_fz1, r_fz2;
    logic [7:0]  r_pix1, r_pix2;
    logic [15:0] r_prod1;
    logic [11:0] r_m2;
    logic [8:0]  r_est2;

    logic        w_en;
    logic [24:0] w_recip_prod;
    logic [12:0] w_est15;
    logic [12:0] w_rem;
    logic [8:0]  w_q;
    logic [7:0]  w_split;

    assign w_en    = !r_v2 || !i_q_stat.full;
    assign o_ready = w_en;
    assign o_push  = r_v2 && !i_q_stat.full;

    assign w_recip_prod = 25'(r_prod1[15:4]) * 25'(RECIP_15);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (w_en) begin
            r_v1 <= i_valid && (i_op != OP_NONE);
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_op1   <= i_op;
            r_fz1   <= (i_frac == 8'd0);
            r_pix1  <= i_pix;
            r_prod1 <= 16'(i_cfg.alpha) * 16'(i_frac);
            r_op2   <= r_op1;
            r_fz2   <= r_fz1;
            r_pix2  <= r_pix1;
            r_m2    <= r_prod1[15:4];
            r_est2  <= w_recip_prod[24:16];
        end
    end

    // The estimate is at most one below the true quotient.
    assign w_est15 = {r_est2, 4'b0000} - {4'b0000, r_est2};
    assign w_rem   = {1'b0, r_m2} - w_est15;
    assign w_q     = r_est2 + ((w_rem >= DIV_15) ? 9'd1 : 9'd0);
    assign w_split = (w_q > {1'b0, i_cfg.alpha}) ? i_cfg.alpha : w_q[7:0];

    always_comb begin
        o_cmd.op        = r_op2;
        o_cmd.frac_zero = r_fz2;
        o_cmd.split     = w_split;
        o_cmd.pix       = r_pix2;
    end

endmodule

FILE: rtl/lbce_queue.sv
module lbce_queue import lbce_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_cmd    i_cmd,
    input  logic    i_pop,
    output t_cmd    o_cmd,
    output t_q_stat o_stat
);

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr, r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd        = r_mem[r_rd_ptr];
    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == (QUEUE_AW+1)'(QUEUE_DEPTH));

endmodule

FILE: rtl/lbce_back.sv
module lbce_back import lbce_pkg::*; #(
    parameter int STRIP_PIXELS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cfg        i_cfg,
    input  t_cmd        i_cmd,
    input  t_q_stat     i_q_stat,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_data
);

    localparam logic [8:0] LP_STRIP = 9'(STRIP_PIXELS);

    logic [7:0]  r_pos, n_pos;
    logic        r_dir, n_dir;
    logic [7:0]  r_head_a, n_head_a;
    logic [7:0]  r_tail_a, n_tail_a;
    logic        r_ovalid;
    logic [31:0] r_odata;

    logic        w_out_free;
    logic [8:0]  w_tail;
    logic [8:0]  w_pix9;
    logic        w_lit;
    logic [7:0]  w_alpha;

    assign w_out_free = !r_ovalid || i_ready;
    assign o_pop      = !i_q_stat.empty && ((i_cmd.op != OP_QUERY) || w_out_free);
    assign w_tail     = {1'b0, r_pos} + {2'b00, i_cfg.seg_len};
    assign w_pix9     = {1'b0, i_cmd.pix};

    always_comb begin
        n_pos    = r_pos;
        n_dir    = r_dir;
        n_head_a = r_head_a;
        n_tail_a = r_tail_a;
        case (i_cmd.op)
            OP_TICK: begin
                if (i_cmd.frac_zero) begin
                    n_dir = r_dir ^ ((r_pos == 8'd0) || (w_tail >= LP_STRIP));
                    n_pos = n_dir ? (r_pos - 8'd1) : (r_pos + 8'd1);
                end
                if (n_dir) begin
                    n_head_a = i_cmd.split;
                    n_tail_a = i_cfg.alpha - i_cmd.split;
                end else begin
                    n_tail_a = i_cmd.split;
                    n_head_a = i_cfg.alpha - i_cmd.split;
                end
            end
            OP_RESTART: begin
                n_pos    = i_cfg.start_pos;
                n_dir    = i_cfg.start_rev;
                n_head_a = 8'd0;
                n_tail_a = 8'd0;
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        w_lit   = 1'b1;
        w_alpha = 8'd0;
        if (i_cmd.pix == r_pos) begin
            w_alpha = r_head_a;
        end else if ((i_cmd.pix > r_pos) && (w_pix9 < w_tail)) begin
            w_alpha = i_cfg.alpha;
        end else if (w_pix9 == w_tail) begin
            w_alpha = r_tail_a;
        end else begin
            w_lit = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos    <= 8'd0;
            r_dir    <= 1'b0;
            r_head_a <= 8'd0;
            r_tail_a <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_pos    <= n_pos;
                r_dir    <= n_dir;
                r_head_a <= n_head_a;
                r_tail_a <= n_tail_a;
            end
            if (o_pop && (i_cmd.op == OP_QUERY)) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && (i_cmd.op == OP_QUERY)) begin
            r_odata <= {w_alpha,
                        w_lit ? i_cfg.blue  : 8'd0,
                        w_lit ? i_cfg.green : 8'd0,
                        w_lit ? i_cfg.red   : 8'd0};
        end
    end

    assign o_valid = r_ovalid;
    assign o_data  = r_odata;

endmodule

FILE: dv/led_bouncing_chase_effect_tb.sv
module led_bouncing_chase_effect_tb import lbce_pkg::*; ();

    localparam int STRIP_PIXELS = 64;

    class chase_scoreboard;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
        logic [7:0]  alpha;
        logic [6:0]  seg_len;
        logic [7:0]  start_pos;
        logic        start_rev;
        logic [7:0]  head;
        logic        down;
        logic [7:0]  head_a;
        logic [7:0]  tail_a;
        logic [31:0] pixel_q[$];
        int errors;
        int n_ticks;
        int n_queries;
        int n_restarts;
        int n_ignored;
        int n_checked;

        function new();
            red = '0;
            green = '0;
            blue = '0;
            alpha = '0;
            seg_len = '0;
            start_pos = '0;
            start_rev = 1'b0;
            head = '0;
            down = 1'b0;
            head_a = '0;
            tail_a = '0;
            errors = 0;
            n_ticks = 0;
            n_queries = 0;
            n_restarts = 0;
            n_ignored = 0;
            n_checked = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] v);
            case (idx)
                CFG_RED:       red = v;
                CFG_GREEN:     green = v;
                CFG_BLUE:      blue = v;
                CFG_ALPHA:     alpha = v;
                CFG_SEG_LEN:   seg_len = v[6:0];
                CFG_START_POS: start_pos = v;
                CFG_START_REV: start_rev = v[0];
                default: ;
            endcase
        endfunction

        function void step_beat(logic [7:0] frac);
            int q;
            if (frac == 8'd0) begin
                if (head == 8'd0 || int'(head) + int'(seg_len) >= STRIP_PIXELS)
                    down = ~down;
                head = down ? head - 8'd1 : head + 8'd1;
            end
            q = (int'(alpha) * int'(frac)) / 240;
            if (q > int'(alpha))
                q = int'(alpha);
            if (down) begin
                head_a = q[7:0];
                tail_a = alpha - q[7:0];
            end else begin
                tail_a = q[7:0];
                head_a = alpha - q[7:0];
            end
        endfunction

        function logic [31:0] shade_pixel(logic [7:0] pix);
            logic [8:0] tail_pos;
            logic [7:0] a;
            logic       lit;
            tail_pos = {1'b0, head} + {2'b00, seg_len};
            lit = 1'b1;
            if (pix == head)
                a = head_a;
            else if ({1'b0, pix} > {1'b0, head} && {1'b0, pix} < tail_pos)
                a = alpha;
            else if ({1'b0, pix} == tail_pos)
                a = tail_a;
            else begin
                a = '0;
                lit = 1'b0;
            end
            return lit ? {a, blue, green, red} : {a, 24'd0};
        endfunction

        function void note_request(logic [1:0] op, logic [7:0] frac, logic [7:0] pix);
            case (op)
                OP_TICK: begin
                    step_beat(frac);
                    n_ticks++;
                end
                OP_QUERY: begin
                    pixel_q.push_back(shade_pixel(pix));
                    n_queries++;
                end
                OP_RESTART: begin
                    head = start_pos;
                    down = start_rev;
                    head_a = '0;
                    tail_a = '0;
                    n_restarts++;
                end
                default: n_ignored++;
            endcase
        endfunction

        function void check_pixel(logic [31:0] got);
            string names[4];
            logic [31:0] want;
            names = '{"out_red", "out_green", "out_blue", "out_alpha"};
            if (pixel_q.size() == 0) begin
                $error("unexpected pixel result %h", got);
                errors++;
                return;
            end
            want = pixel_q.pop_front();
            n_checked++;
            for (int i = 0; i < 4; i++) begin
                if (got[8*i +: 8] !== want[8*i +: 8]) begin
                    $error("%s: expected %0d, actual %0d", names[i], want[8*i +: 8],
                           got[8*i +: 8]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return pixel_q.size();
        endfunction
    endclass

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [15:0] s_data;
    logic [1:0]  s_user;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_data;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [7:0]  cfg_wdata;

    chase_scoreboard sb;
    int tx_idle_pct = 32;
    int rx_idle_pct = 32;
    int hold_left = 0;
    int beat_pos = 0;
    int n_settings = 0;

    led_bouncing_chase_effect #(
        .STRIP_PIXELS(STRIP_PIXELS)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .i_s_axis_tvalid(s_valid),
        .o_s_axis_tready(s_ready),
        .i_s_axis_tdata(s_data),
        .i_s_axis_tuser(s_user),
        .o_m_axis_tvalid(m_valid),
        .i_m_axis_tready(m_ready),
        .o_m_axis_tdata(m_data),
        .i_cfg_we(cfg_we),
        .i_cfg_addr(cfg_addr),
        .i_cfg_wdata(cfg_wdata)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= rx_idle_pct);
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_valid && m_ready)
            sb.check_pixel(m_data);
    end

    initial begin
        #4_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    task automatic send_request(input logic [1:0] op, input logic [7:0] frac,
                                input logic [7:0] pix);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= op;
        s_data <= {pix, frac};
        @(posedge i_clk);
        while (!s_ready)
            @(posedge i_clk);
        sb.note_request(op, frac, pix);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (sb.pending() > 0)
            @(negedge i_clk);
        repeat (16) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [7:0] v);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= v;
        sb.set_reg(idx, v);
        @(negedge i_clk);
    endtask

    task automatic program_chase(input logic [7:0] r, input logic [7:0] g, input logic [7:0] b,
                                 input logic [7:0] a, input logic [6:0] len,
                                 input logic [7:0] start, input logic rev);
        write_reg(CFG_RED, r);
        write_reg(CFG_GREEN, g);
        write_reg(CFG_BLUE, b);
        write_reg(CFG_ALPHA, a);
        write_reg(CFG_SEG_LEN, {1'b0, len});
        write_reg(CFG_START_POS, start);
        write_reg(CFG_START_REV, {7'd0, rev});
        cfg_we <= 1'b0;
        n_settings++;
    endtask

    function automatic logic [7:0] near_pixel();
        int off;
        if ($urandom_range(3) == 0)
            return 8'($urandom_range(255));
        off = $urandom_range(int'(sb.seg_len) + 4) - 2;
        return 8'(int'(sb.head) + off);
    endfunction

    task automatic random_item();
        int r;
        logic [7:0] frac;
        r = $urandom_range(99);
        if (r < 30) begin
            beat_pos += $urandom_range(60, 1);
            if (beat_pos >= 240)
                beat_pos = 0;
            frac = ($urandom_range(19) == 0) ? 8'($urandom_range(255)) : 8'(beat_pos);
            send_request(OP_TICK, frac, 8'($urandom_range(255)));
        end else if (r < 85) begin
            send_request(OP_QUERY, 8'($urandom_range(255)), near_pixel());
        end else if (r < 93) begin
            beat_pos = 0;
            send_request(OP_TICK, 8'd0, 8'($urandom_range(255)));
        end else if (r < 96) begin
            send_request(OP_RESTART, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end else begin
            send_request(OP_NONE, 8'($urandom_range(255)), 8'($urandom_range(255)));
        end
    endtask

    initial begin
        sb = new();
        i_rst_n = 1'b0;
        s_valid = 1'b0;
        s_data = '0;
        s_user = OP_TICK;
        cfg_we = 1'b0;
        cfg_addr = CFG_RED;
        cfg_wdata = '0;
        repeat (11) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Segment moving up from pixel 10, with head, inside, tail and clear pixels.
        program_chase(8'h12, 8'h34, 8'h56, 8'hff, 7'd5, 8'd10, 1'b0);
        send_request(OP_QUERY, 8'd0, 8'd10);
        send_request(OP_QUERY, 8'd255, 8'd0);
        send_request(OP_RESTART, 8'd255, 8'd255);
        send_request(OP_QUERY, 8'd0, 8'd10);
        send_request(OP_QUERY, 8'd0, 8'd12);
        send_request(OP_QUERY, 8'd0, 8'd15);
        send_request(OP_QUERY, 8'd0, 8'd16);
        send_request(OP_QUERY, 8'd0, 8'd9);
        send_request(OP_TICK, 8'd0, 8'd0);
        send_request(OP_TICK, 8'd60, 8'd255);
        send_request(OP_QUERY, 8'd0, 8'd11);
        send_request(OP_QUERY, 8'd0, 8'd16);
        send_request(OP_TICK, 8'd240, 8'd0);
        send_request(OP_TICK, 8'd255, 8'd0);
        send_request(OP_QUERY, 8'd0, 8'd11);
        send_request(OP_NONE, 8'd0, 8'd11);
        send_request(OP_QUERY, 8'd0, 8'd11);
        drain();

        // Bounce at pixel zero, wrap to 255 and a tail beyond 8 bits.
        program_chase(8'hff, 8'h00, 8'hff, 8'hff, 7'd127, 8'd0, 1'b0);
        send_request(OP_RESTART, 8'd0, 8'd0);
        send_request(OP_TICK, 8'd0, 8'd0);
        send_request(OP_QUERY, 8'd0, 8'd255);
        send_request(OP_QUERY, 8'd0, 8'd0);
        send_request(OP_TICK, 8'd239, 8'd0);
        send_request(OP_QUERY, 8'd0, 8'd255);
        send_request(OP_TICK, 8'd0, 8'd0);
        send_request(OP_QUERY, 8'd0, 8'd127);
        send_request(OP_QUERY, 8'd0, 8'd100);
        drain();

        for (int p = 0; p < 7; p++) begin
            if (p == 0)
                program_chase(8'd0, 8'd0, 8'd0, 8'd0, 7'd0, 8'd0, 1'b0);
            else if (p == 1)
                program_chase(8'd255, 8'd255, 8'd255, 8'd255, 7'd127, 8'd255, 1'b1);
            else
                program_chase(8'($urandom_range(255)), 8'($urandom_range(255)),
                              8'($urandom_range(255)), 8'($urandom_range(255)),
                              7'((p % 2) ? $urandom_range(127) : $urandom_range(24)),
                              8'($urandom_range(63)), 1'($urandom_range(1)));
            tx_idle_pct = (p == 3) ? 0 : 32;
            rx_idle_pct = (p == 3) ? 0 : 32;
            beat_pos = 0;
            send_request(OP_RESTART, 8'($urandom_range(255)), 8'($urandom_range(255)));
            for (int k = 0; k < 240; k++) begin
                if (p == 4 && k == 100) begin
                    // The receiver stalls for a long time while query requests keep coming.
                    s_valid <= 1'b0;
                    @(posedge i_clk);
                    hold_left = 300;
                    @(negedge i_clk);
                    repeat (40)
                        send_request(OP_QUERY, 8'($urandom_range(255)), near_pixel());
                end
                random_item();
            end
            drain();
        end

        $display("Covered %0d ticks, %0d pixel queries, %0d restarts, %0d ignored requests.",
                 sb.n_ticks, sb.n_queries, sb.n_restarts, sb.n_ignored);
        $display("Compared %0d pixel results over %0d register settings.",
                 sb.n_checked, n_settings);
        if (sb.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
